>>> rtl/mbi_pkg.sv
// Shared types and constants for the boot information parser.
// No dependencies; imported by multiboot_info_parser_top.
package mbi_pkg;

   localparam int WIDX_W = 30;

   localparam logic [31:0] MAGIC_MB1       = 32'h2BAD_B002;
   localparam logic [31:0] MAGIC_MB2       = 32'h36D7_6289;
   localparam logic [31:0] MB1_FB_FLAG     = 32'h0000_1000;
   localparam logic [31:0] MB2_MIN_TOTAL   = 32'd16;
   localparam logic [31:0] MB2_MIN_TAG     = 32'd8;
   localparam logic [31:0] MB2_MIN_FB_SIZE = 32'd32;
   localparam logic [31:0] MB2_TAG_END     = 32'd0;
   localparam logic [31:0] MB2_TAG_FB      = 32'd8;
   localparam logic [31:0] ALIGN_ROUND     = 32'd7;

   localparam logic [WIDX_W-1:0] MB1_FB_FIRST = WIDX_W'(22);
   localparam logic [WIDX_W-1:0] MB1_FB_LAST  = WIDX_W'(27);

   // word offsets within a tag
   localparam logic [WIDX_W-1:0] REL_TYPE    = WIDX_W'(0);
   localparam logic [WIDX_W-1:0] REL_SIZE    = WIDX_W'(1);
   localparam logic [WIDX_W-1:0] REL_FB_LO   = WIDX_W'(2);
   localparam logic [WIDX_W-1:0] REL_FB_LAST = WIDX_W'(7);

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   localparam logic [1:0] PROTO_NONE = 2'd0;
   localparam logic [1:0] PROTO_MB1  = 2'd1;
   localparam logic [1:0] PROTO_MB2  = 2'd2;

   // framebuffer field select
   localparam logic [2:0] FB_ADDR_LO = 3'd0;
   localparam logic [2:0] FB_ADDR_HI = 3'd1;
   localparam logic [2:0] FB_PITCH   = 3'd2;
   localparam logic [2:0] FB_WIDTH   = 3'd3;
   localparam logic [2:0] FB_HEIGHT  = 3'd4;
   localparam logic [2:0] FB_BPP     = 3'd5;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_MB1     = 5'b00010,
      PH_MB2_HDR = 5'b00100,
      PH_MB2_TAG = 5'b01000,
      PH_MB2_END = 5'b10000
   } phase_type;

   typedef struct packed {
      logic        valid_res;
      logic [1:0]  protocol;
      logic [31:0] flags;
      logic        fb_present;
      logic [63:0] fb_address;
      logic [31:0] fb_pitch;
      logic [31:0] fb_width;
      logic [31:0] fb_height;
      logic [7:0]  fb_bpp;
      logic [7:0]  fb_kind;
      logic [28:0] tag_count;
      logic [31:0] fb_tag_address;
   } res_type;

endpackage

>>> rtl/multiboot_info_parser_top.sv
// Boot information parser, multiboot1 and multiboot2, one word per cycle unless stalled.
// Depends on mbi_pkg.
//
// Usage:
//   req channel: a start word (command 0) carries the boot magic and the
//   info base address; data words (command 1) then stream the info
//   structure as 32-bit little-endian words from offset 0 upward.
//   rsp channel: one summary per completed parse, issued on the input word at
//   which the parse ends (start word for bad magic or missing base).
// Output: the summary is registered into the result queue as the word
//   that ends the parse is accepted.
// Throughput: one input word per cycle while req_stall is low; each word
//   is parsed by one pass of logic between the parse state registers and
//   a two-entry result queue.
// Stall: the req side keeps accepting while one summary waits in the
//   queue; req_stall rises only when both queue entries are held.
// Reset: parser returns to idle, queue empties; data words while idle
//   are dropped.
module multiboot_info_parser_top
   import mbi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_word,
   input  logic [31:0] req_base_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_valid_res,
   output logic [1:0]  rsp_protocol,
   output logic [31:0] rsp_flags,
   output logic        rsp_fb_present,
   output logic [63:0] rsp_fb_address,
   output logic [31:0] rsp_fb_pitch,
   output logic [31:0] rsp_fb_width,
   output logic [31:0] rsp_fb_height,
   output logic [7:0]  rsp_fb_bpp,
   output logic [7:0]  rsp_fb_kind,
   output logic [28:0] rsp_tag_count,
   output logic [31:0] rsp_fb_tag_address
);

   // parse state
   phase_type         phase_ff, phase_in;
   logic [WIDX_W-1:0] widx_ff, widx_in;
   logic [WIDX_W-1:0] tag_start_ff, tag_start_in;
   logic [WIDX_W:0]   tag_end_ff, tag_end_in;
   logic [WIDX_W-1:0] rel_ff, rel_in;
   logic [31:0]       total_ff, total_in;
   logic              tag_is_fb_ff, tag_is_fb_in;
   logic              walk_done_ff, walk_done_in;
   logic [31:0]       base_ff, base_in;
   logic [1:0]        proto_ff, proto_in;
   logic [31:0]       flags_ff, flags_in;
   logic              fb_present_ff, fb_present_in;
   logic [28:0]       tag_count_ff, tag_count_in;
   logic [31:0]       fb_tag_addr_ff, fb_tag_addr_in;

   // framebuffer fields
   logic [31:0] fb_addr_lo_ff, fb_addr_lo_in;
   logic [31:0] fb_addr_hi_ff, fb_addr_hi_in;
   logic [31:0] fb_pitch_ff, fb_pitch_in;
   logic [31:0] fb_width_ff, fb_width_in;
   logic [31:0] fb_height_ff, fb_height_in;
   logic [7:0]  fb_bpp_ff, fb_bpp_in;
   logic [7:0]  fb_kind_ff, fb_kind_in;

   // result queue
   res_type    res_q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;

   logic              req_accept, rsp_pop;
   logic              emit, emit_ok;
   logic              cap_en;
   logic [2:0]        cap_k;
   logic              at_bound;
   logic [WIDX_W-1:0] ts_eff, rel_eff;
   logic [31:0]       size_round;
   logic [WIDX_W-1:0] size_words;
   logic [WIDX_W:0]   tag_end_calc;
   logic              walk_done_calc;
   res_type           res_word;

   assign req_stall  = (cnt_ff == 2'd2);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (cnt_ff != 2'd0);
   assign rsp_pop    = rsp_valid && !rsp_stall;

   // tag walk helpers
   assign at_bound     = ({1'b0, widx_ff} == tag_end_ff);
   assign ts_eff       = at_bound ? widx_ff : tag_start_ff;
   assign rel_eff      = at_bound ? '0 : rel_ff;
   assign size_round   = req_word + ALIGN_ROUND;
   assign size_words   = {size_round[31:3], 1'b0};
   assign tag_end_calc = {1'b0, tag_start_ff} + {1'b0, size_words};
   assign walk_done_calc = ({1'b0, tag_end_calc, 2'b00} + 34'd8) > {2'b00, total_ff};

   always_comb begin
      phase_in       = phase_ff;
      widx_in        = widx_ff;
      tag_start_in   = tag_start_ff;
      tag_end_in     = tag_end_ff;
      rel_in         = rel_ff;
      total_in       = total_ff;
      tag_is_fb_in   = tag_is_fb_ff;
      walk_done_in   = walk_done_ff;
      base_in        = base_ff;
      proto_in       = proto_ff;
      flags_in       = flags_ff;
      fb_present_in  = fb_present_ff;
      tag_count_in   = tag_count_ff;
      fb_tag_addr_in = fb_tag_addr_ff;
      emit           = 1'b0;
      emit_ok        = 1'b0;
      cap_en         = 1'b0;
      cap_k          = FB_ADDR_LO;

      if (req_accept) begin
         if (req_command == CMD_START) begin
            widx_in        = '0;
            tag_start_in   = '0;
            tag_end_in     = '0;
            rel_in         = '0;
            total_in       = '0;
            tag_is_fb_in   = 1'b0;
            walk_done_in   = 1'b0;
            flags_in       = '0;
            fb_present_in  = 1'b0;
            tag_count_in   = '0;
            fb_tag_addr_in = '0;
            base_in        = req_base_address;
            if (req_word == MAGIC_MB1) begin
               proto_in = PROTO_MB1;
            end else if (req_word == MAGIC_MB2) begin
               proto_in = PROTO_MB2;
            end else begin
               proto_in = PROTO_NONE;
            end
            if (req_base_address == '0 || proto_in == PROTO_NONE) begin
               emit = 1'b1;
            end else if (proto_in == PROTO_MB1) begin
               phase_in = PH_MB1;
            end else begin
               phase_in = PH_MB2_HDR;
            end
         end else begin
            if (phase_ff != PH_IDLE) begin
               widx_in = widx_ff + WIDX_W'(1);
            end
            unique case (phase_ff)
               PH_IDLE: begin
               end
               PH_MB1: begin
                  if (widx_ff == '0) begin
                     flags_in = req_word;
                     if ((req_word & MB1_FB_FLAG) == '0) begin
                        emit    = 1'b1;
                        emit_ok = 1'b1;
                     end
                  end else if (widx_ff >= MB1_FB_FIRST && widx_ff <= MB1_FB_LAST) begin
                     cap_en = 1'b1;
                     cap_k  = 3'(widx_ff - MB1_FB_FIRST);
                     if (widx_ff == MB1_FB_LAST) begin
                        fb_present_in = 1'b1;
                        emit          = 1'b1;
                        emit_ok       = 1'b1;
                     end
                  end
               end
               PH_MB2_HDR: begin
                  if (widx_ff == '0) begin
                     total_in = req_word;
                     if (req_word < MB2_MIN_TOTAL) begin
                        emit = 1'b1;
                     end
                  end else begin
                     tag_start_in = WIDX_W'(2);
                     tag_end_in   = (WIDX_W + 1)'(2);
                     rel_in       = '0;
                     phase_in     = PH_MB2_TAG;
                  end
               end
               PH_MB2_TAG, PH_MB2_END: begin
                  tag_start_in = ts_eff;
                  rel_in       = rel_eff + WIDX_W'(1);
                  if (rel_eff == REL_TYPE) begin
                     phase_in     = (req_word == MB2_TAG_END) ? PH_MB2_END : PH_MB2_TAG;
                     tag_is_fb_in = (req_word == MB2_TAG_FB);
                  end else if (rel_eff == REL_SIZE) begin
                     if (req_word < MB2_MIN_TAG) begin
                        emit = 1'b1;
                     end else begin
                        tag_count_in = tag_count_ff + 29'd1;
                        if (phase_ff == PH_MB2_END) begin
                           emit    = 1'b1;
                           emit_ok = 1'b1;
                        end else begin
                           tag_end_in   = tag_end_calc;
                           walk_done_in = walk_done_calc;
                           tag_is_fb_in = tag_is_fb_ff && (req_word >= MB2_MIN_FB_SIZE);
                           if (tag_is_fb_in) begin
                              fb_tag_addr_in = base_ff + {tag_start_ff, 2'b00};
                           end else if (walk_done_calc) begin
                              emit    = 1'b1;
                              emit_ok = 1'b1;
                           end
                        end
                     end
                  end else if (tag_is_fb_ff && rel_eff >= REL_FB_LO
                               && rel_eff <= REL_FB_LAST) begin
                     cap_en = 1'b1;
                     cap_k  = 3'(rel_eff - REL_FB_LO);
                     if (rel_eff == REL_FB_LAST) begin
                        fb_present_in = 1'b1;
                        tag_is_fb_in  = 1'b0;
                        if (walk_done_ff) begin
                           emit    = 1'b1;
                           emit_ok = 1'b1;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         if (emit) begin
            phase_in = PH_IDLE;
         end
      end
   end

   always_comb begin
      fb_addr_lo_in = fb_addr_lo_ff;
      fb_addr_hi_in = fb_addr_hi_ff;
      fb_pitch_in   = fb_pitch_ff;
      fb_width_in   = fb_width_ff;
      fb_height_in  = fb_height_ff;
      fb_bpp_in     = fb_bpp_ff;
      fb_kind_in    = fb_kind_ff;
      if (cap_en) begin
         unique case (cap_k)
            FB_ADDR_LO: fb_addr_lo_in = req_word;
            FB_ADDR_HI: fb_addr_hi_in = req_word;
            FB_PITCH:   fb_pitch_in   = req_word;
            FB_WIDTH:   fb_width_in   = req_word;
            FB_HEIGHT:  fb_height_in  = req_word;
            FB_BPP: begin
               fb_bpp_in  = req_word[7:0];
               fb_kind_in = req_word[15:8];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      res_word.valid_res      = emit_ok;
      res_word.protocol       = proto_in;
      res_word.flags          = flags_in;
      res_word.fb_present     = fb_present_in;
      res_word.fb_address     = fb_present_in ? {fb_addr_hi_in, fb_addr_lo_in} : '0;
      res_word.fb_pitch       = fb_present_in ? fb_pitch_in : '0;
      res_word.fb_width       = fb_present_in ? fb_width_in : '0;
      res_word.fb_height      = fb_present_in ? fb_height_in : '0;
      res_word.fb_bpp         = fb_present_in ? fb_bpp_in : '0;
      res_word.fb_kind        = fb_present_in ? fb_kind_in : '0;
      res_word.tag_count      = tag_count_in;
      res_word.fb_tag_address = fb_tag_addr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         widx_ff        <= '0;
         tag_start_ff   <= '0;
         tag_end_ff     <= '0;
         rel_ff         <= '0;
         total_ff       <= '0;
         tag_is_fb_ff   <= 1'b0;
         walk_done_ff   <= 1'b0;
         base_ff        <= '0;
         proto_ff       <= PROTO_NONE;
         flags_ff       <= '0;
         fb_present_ff  <= 1'b0;
         tag_count_ff   <= '0;
         fb_tag_addr_ff <= '0;
         wr_ptr_ff      <= 1'b0;
         rd_ptr_ff      <= 1'b0;
         cnt_ff         <= 2'd0;
      end else begin
         phase_ff       <= phase_in;
         widx_ff        <= widx_in;
         tag_start_ff   <= tag_start_in;
         tag_end_ff     <= tag_end_in;
         rel_ff         <= rel_in;
         total_ff       <= total_in;
         tag_is_fb_ff   <= tag_is_fb_in;
         walk_done_ff   <= walk_done_in;
         base_ff        <= base_in;
         proto_ff       <= proto_in;
         flags_ff       <= flags_in;
         fb_present_ff  <= fb_present_in;
         tag_count_ff   <= tag_count_in;
         fb_tag_addr_ff <= fb_tag_addr_in;
         if (emit) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (rsp_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, emit} - {1'b0, rsp_pop};
      end
   end

   always_ff @(posedge clock) begin
      fb_addr_lo_ff <= fb_addr_lo_in;
      fb_addr_hi_ff <= fb_addr_hi_in;
      fb_pitch_ff   <= fb_pitch_in;
      fb_width_ff   <= fb_width_in;
      fb_height_ff  <= fb_height_in;
      fb_bpp_ff     <= fb_bpp_in;
      fb_kind_ff    <= fb_kind_in;
      if (emit) begin
         res_q_ff[wr_ptr_ff] <= res_word;
      end
   end

   assign rsp_valid_res      = res_q_ff[rd_ptr_ff].valid_res;
   assign rsp_protocol       = res_q_ff[rd_ptr_ff].protocol;
   assign rsp_flags          = res_q_ff[rd_ptr_ff].flags;
   assign rsp_fb_present     = res_q_ff[rd_ptr_ff].fb_present;
   assign rsp_fb_address     = res_q_ff[rd_ptr_ff].fb_address;
   assign rsp_fb_pitch       = res_q_ff[rd_ptr_ff].fb_pitch;
   assign rsp_fb_width       = res_q_ff[rd_ptr_ff].fb_width;
   assign rsp_fb_height      = res_q_ff[rd_ptr_ff].fb_height;
   assign rsp_fb_bpp         = res_q_ff[rd_ptr_ff].fb_bpp;
   assign rsp_fb_kind        = res_q_ff[rd_ptr_ff].fb_kind;
   assign rsp_tag_count      = res_q_ff[rd_ptr_ff].tag_count;
   assign rsp_fb_tag_address = res_q_ff[rd_ptr_ff].fb_tag_address;

   // checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue overflow");

   a_bad_base_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_command == CMD_START && req_base_address == '0 |=> rsp_valid)
      else $error("missing base gave no summary");

   a_fb_zeroed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fb_present |-> rsp_fb_address == '0 && rsp_fb_pitch == '0)
      else $error("framebuffer fields leaked without capture");

   a_mb2_only_tags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_protocol != PROTO_MB2 |-> rsp_tag_count == '0
      && rsp_fb_tag_address == '0)
      else $error("tag fields set outside multiboot2");

endmodule

>>> tb/tb_multiboot_info_parser_top.sv
`timescale 1ns / 1ps
// Testbench for multiboot_info_parser_top: directed and random info streams,
// each summary checked against an in-bench parser model.
// Depends on mbi_pkg and the multiboot_info_parser_top RTL.
module tb_multiboot_info_parser_top;
   import mbi_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = CMD_START;
   logic [31:0] req_word = '0;
   logic [31:0] req_base_address = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_valid_res;
   logic [1:0]  rsp_protocol;
   logic [31:0] rsp_flags;
   logic        rsp_fb_present;
   logic [63:0] rsp_fb_address;
   logic [31:0] rsp_fb_pitch;
   logic [31:0] rsp_fb_width;
   logic [31:0] rsp_fb_height;
   logic [7:0]  rsp_fb_bpp;
   logic [7:0]  rsp_fb_kind;
   logic [28:0] rsp_tag_count;
   logic [31:0] rsp_fb_tag_address;

   multiboot_info_parser_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_word           (req_word),
      .req_base_address   (req_base_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_valid_res      (rsp_valid_res),
      .rsp_protocol       (rsp_protocol),
      .rsp_flags          (rsp_flags),
      .rsp_fb_present     (rsp_fb_present),
      .rsp_fb_address     (rsp_fb_address),
      .rsp_fb_pitch       (rsp_fb_pitch),
      .rsp_fb_width       (rsp_fb_width),
      .rsp_fb_height      (rsp_fb_height),
      .rsp_fb_bpp         (rsp_fb_bpp),
      .rsp_fb_kind        (rsp_fb_kind),
      .rsp_tag_count      (rsp_tag_count),
      .rsp_fb_tag_address (rsp_fb_tag_address)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser model state
   phase_type   parse_phase;
   logic [31:0] byte_pos;
   logic [31:0] tag_first;
   logic [32:0] tag_next;
   logic [31:0] info_total;
   logic        in_fb_tag;
   logic [31:0] base_addr;
   logic [1:0]  proto;
   logic [31:0] flags_word;
   logic [63:0] fb_addr;
   logic [31:0] fb_pitch_q;
   logic [31:0] fb_width_q;
   logic [31:0] fb_height_q;
   logic [31:0] fb_mode;
   logic        fb_seen;
   logic [28:0] tags_seen;
   logic [31:0] fb_tag_addr;

   res_type summaries_due[$];
   int      fault_count = 0;
   int      items_fed = 0;
   bit      calm = 1'b0;

   function automatic void clear_parse();
      parse_phase = PH_IDLE;
      byte_pos    = '0;
      tag_first   = '0;
      tag_next    = '0;
      info_total  = '0;
      in_fb_tag   = 1'b0;
      base_addr   = '0;
      proto       = PROTO_NONE;
      flags_word  = '0;
      fb_addr     = '0;
      fb_pitch_q  = '0;
      fb_width_q  = '0;
      fb_height_q = '0;
      fb_mode     = '0;
      fb_seen     = 1'b0;
      tags_seen   = '0;
      fb_tag_addr = '0;
   endfunction

   function automatic void finish_parse(input logic ok);
      res_type s;
      s.valid_res      = ok;
      s.protocol       = proto;
      s.flags          = flags_word;
      s.fb_present     = fb_seen;
      s.fb_address     = fb_seen ? fb_addr : '0;
      s.fb_pitch       = fb_seen ? fb_pitch_q : '0;
      s.fb_width       = fb_seen ? fb_width_q : '0;
      s.fb_height      = fb_seen ? fb_height_q : '0;
      s.fb_bpp         = fb_seen ? fb_mode[7:0] : '0;
      s.fb_kind        = fb_seen ? fb_mode[15:8] : '0;
      s.tag_count      = tags_seen;
      s.fb_tag_address = fb_tag_addr;
      summaries_due.push_back(s);
      parse_phase = PH_IDLE;
   endfunction

   function automatic void store_fb_word(input logic [2:0] k, input logic [31:0] w);
      case (k)
         FB_ADDR_LO: fb_addr[31:0]  = w;
         FB_ADDR_HI: fb_addr[63:32] = w;
         FB_PITCH:   fb_pitch_q     = w;
         FB_WIDTH:   fb_width_q     = w;
         FB_HEIGHT:  fb_height_q    = w;
         FB_BPP:     fb_mode        = w;
         default: ;
      endcase
   endfunction

   function automatic logic walk_over();
      return ({31'b0, tag_next} + 64'd8) > {32'b0, info_total};
   endfunction

   function automatic void predict_word(input logic cmd, input logic [31:0] w,
                                        input logic [31:0] base);
      logic [WIDX_W-1:0] idx;
      logic [31:0]       rel;
      logic [WIDX_W-1:0] rel_w;
      if (cmd == CMD_START) begin
         clear_parse();
         base_addr = base;
         if (w == MAGIC_MB1) proto = PROTO_MB1;
         else if (w == MAGIC_MB2) proto = PROTO_MB2;
         if (base == '0 || proto == PROTO_NONE) finish_parse(1'b0);
         else parse_phase = (proto == PROTO_MB1) ? PH_MB1 : PH_MB2_HDR;
         return;
      end
      case (parse_phase)
         PH_IDLE: return;
         PH_MB1: begin
            idx = byte_pos[31:2];
            if (idx == '0) begin
               flags_word = w;
               if ((w & MB1_FB_FLAG) == '0) finish_parse(1'b1);
            end else if (idx >= MB1_FB_FIRST && idx <= MB1_FB_LAST) begin
               store_fb_word(3'(idx - MB1_FB_FIRST), w);
               if (idx == MB1_FB_LAST) begin
                  fb_seen = 1'b1;
                  finish_parse(1'b1);
               end
            end
         end
         PH_MB2_HDR: begin
            if (byte_pos == '0) begin
               info_total = w;
               if (w < MB2_MIN_TOTAL) finish_parse(1'b0);
            end else begin
               tag_first   = 32'd8;
               tag_next    = 33'd8;
               parse_phase = PH_MB2_TAG;
            end
         end
         default: begin
            if ({1'b0, byte_pos} == tag_next) tag_first = byte_pos;
            rel   = byte_pos - tag_first;
            rel_w = rel[31:2];
            if (rel_w == REL_TYPE) begin
               parse_phase = (w == MB2_TAG_END) ? PH_MB2_END : PH_MB2_TAG;
               in_fb_tag   = (w == MB2_TAG_FB);
            end else if (rel_w == REL_SIZE) begin
               if (w < MB2_MIN_TAG) begin
                  finish_parse(1'b0);
               end else begin
                  tags_seen = tags_seen + 29'd1;
                  if (parse_phase == PH_MB2_END) begin
                     finish_parse(1'b1);
                  end else begin
                     // rounding drops bit 32, so sizes near 2^32 fold back
                     tag_next  = {1'b0, tag_first}
                               + (({1'b0, w} + 33'(ALIGN_ROUND)) & 33'h0_FFFF_FFF8);
                     in_fb_tag = in_fb_tag && (w >= MB2_MIN_FB_SIZE);
                     if (in_fb_tag) fb_tag_addr = base_addr + tag_first;
                     else if (walk_over()) finish_parse(1'b1);
                  end
               end
            end else if (in_fb_tag && rel_w >= REL_FB_LO && rel_w <= REL_FB_LAST) begin
               store_fb_word(3'(rel_w - REL_FB_LO), w);
               if (rel_w == REL_FB_LAST) begin
                  fb_seen   = 1'b1;
                  in_fb_tag = 1'b0;
                  if (walk_over()) finish_parse(1'b1);
               end
            end
         end
      endcase
      byte_pos = byte_pos + 32'd4;
   endfunction

   task automatic note_fault(input string what, input logic [63:0] want,
                             input logic [63:0] got);
      fault_count++;
      if (fault_count <= 10)
         $display("%0t %s: expected %h, got %h", $time, what, want, got);
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) note_fault(what, want, got);
   endtask

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 16);
   end

   always @(posedge clock) begin : summary_check
      res_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (summaries_due.size() == 0) begin
            note_fault("summary with none due", 64'd0, 64'd1);
         end else begin
            due = summaries_due.pop_front();
            check_field("valid_res", 64'(due.valid_res), 64'(rsp_valid_res));
            check_field("protocol", 64'(due.protocol), 64'(rsp_protocol));
            check_field("flags", 64'(due.flags), 64'(rsp_flags));
            check_field("fb_present", 64'(due.fb_present), 64'(rsp_fb_present));
            check_field("fb_address", due.fb_address, rsp_fb_address);
            check_field("fb_pitch", 64'(due.fb_pitch), 64'(rsp_fb_pitch));
            check_field("fb_width", 64'(due.fb_width), 64'(rsp_fb_width));
            check_field("fb_height", 64'(due.fb_height), 64'(rsp_fb_height));
            check_field("fb_bpp", 64'(due.fb_bpp), 64'(rsp_fb_bpp));
            check_field("fb_kind", 64'(due.fb_kind), 64'(rsp_fb_kind));
            check_field("tag_count", 64'(due.tag_count), 64'(rsp_tag_count));
            check_field("fb_tag_address", 64'(due.fb_tag_address),
                        64'(rsp_fb_tag_address));
         end
      end
   end

   task automatic send_word(input logic cmd, input logic [31:0] w,
                            input logic [31:0] base);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_word         <= w;
      req_base_address <= base;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cmd == CMD_START || parse_phase != PH_IDLE) items_fed++;
      predict_word(cmd, w, base);
   endtask

   task automatic send_data(input logic [31:0] w);
      send_word(CMD_DATA, w, $urandom);
   endtask

   task automatic run_mb1(input logic [31:0] base, input logic [31:0] flags,
                          input int n_after);
      send_word(CMD_START, MAGIC_MB1, base);
      send_data(flags);
      repeat (n_after) send_data($urandom);
   endtask

   // builds a tag list with random content, then streams up to keep words of it
   task automatic run_mb2(input logic [31:0] base, input int keep);
      logic [31:0] info[$];
      logic [31:0] ttype;
      logic [31:0] tsize;
      logic [31:0] full;
      int          ntags;
      int          kind;
      int          nbody;
      int          sel;
      bit          odd;
      info.push_back(32'd0);
      info.push_back($urandom);
      ntags = $urandom_range(0, 4);
      odd   = 1'b0;
      for (int i = 0; i < ntags && !odd; i++) begin
         kind = $urandom_range(0, 9);
         if (kind <= 2) begin
            ttype = MB2_TAG_FB;
            tsize = 32 + 4 * $urandom_range(0, 2);
         end else if (kind == 3) begin
            ttype = MB2_TAG_FB;
            tsize = $urandom_range(8, 31);
         end else if (kind <= 8) begin
            ttype = $urandom_range(1, 40);
            if (ttype == MB2_TAG_FB) ttype = 32'd9;
            tsize = $urandom_range(8, 40);
         end else begin
            odd   = 1'b1;
            ttype = $urandom;
            case ($urandom_range(0, 3))
               0: tsize = $urandom_range(0, 7);
               1: tsize = 32'hFFFF_FFF0;
               2: tsize = 32'hFFFF_FFFC;
               default: tsize = $urandom | 32'h8000_0000;
            endcase
         end
         info.push_back(ttype);
         info.push_back(tsize);
         nbody = odd ? $urandom_range(0, 4) : int'((((tsize + 7) & ~32'd7) - 8) >> 2);
         repeat (nbody) info.push_back($urandom);
      end
      if (!odd && $urandom_range(0, 4) != 0) begin
         info.push_back(MB2_TAG_END);
         info.push_back(MB2_MIN_TAG);
      end
      full = 32'(info.size() * 4);
      sel  = $urandom_range(0, 19);
      if (sel <= 13) info[0] = full;
      else if (sel <= 15) info[0] = full - 32'd8;
      else if (sel <= 17) info[0] = $urandom_range(16, full + 16);
      else if (sel == 18) info[0] = $urandom_range(0, 15);
      else info[0] = $urandom;
      repeat ($urandom_range(0, 3)) info.push_back($urandom);
      send_word(CMD_START, MAGIC_MB2, base);
      for (int i = 0; i < info.size() && i < keep; i++) send_data(info[i]);
   endtask

   task automatic test_idle_words();
      send_data(32'hFFFF_FFFF);
      send_word(CMD_DATA, 32'h0, 32'h0);
   endtask

   task automatic test_start_rejects();
      send_word(CMD_START, MAGIC_MB1, 32'h0);
      send_word(CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(CMD_START, 32'h0, 32'h1);
      send_word(CMD_START, MAGIC_MB2, 32'h0);
   endtask

   task automatic test_mb1_plain();
      run_mb1(32'hFFFF_FFFF, ~MB1_FB_FLAG, 1);
   endtask

   task automatic test_mb2_short_total();
      send_word(CMD_START, MAGIC_MB2, 32'h0000_1000);
      send_data(MB2_MIN_TOTAL - 32'd1);
   endtask

   task automatic test_mb2_end_tag();
      send_word(CMD_START, MAGIC_MB2, 32'h8000_0000);
      send_data(MB2_MIN_TOTAL);
      send_data(32'h0);
      send_data(MB2_TAG_END);
      send_data(MB2_MIN_TAG);
   endtask

   task automatic test_tag_too_small();
      send_word(CMD_START, MAGIC_MB2, 32'h0010_0000);
      send_data(32'd24);
      send_data(32'h0);
      send_data(32'd3);
      send_data(MB2_MIN_TAG - 32'd1);
   endtask

   task automatic test_abandoned_parse();
      send_word(CMD_START, MAGIC_MB2, 32'h0000_2000);
      send_data(32'd64);
      send_data(32'h0);
      run_mb1(32'h4, 32'h0, 0);
   endtask

   task automatic test_random_streams();
      logic [31:0] base;
      logic [31:0] flags;
      logic [31:0] w;
      int          seq;
      int          pick;
      int          n_after;
      seq = 0;
      while (items_fed < 600) begin
         calm = (seq >= 10 && seq < 17);
         pick = $urandom_range(0, 19);
         base = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFF8 : ($urandom | 32'h1);
         if (pick <= 6) begin
            run_mb2(base, 1000);
         end else if (pick == 7) begin
            run_mb2(base, $urandom_range(1, 10));
         end else if (pick <= 15) begin
            flags = $urandom;
            if ($urandom_range(0, 3) != 0) begin
               flags   = flags | MB1_FB_FLAG;
               n_after = (pick >= 14) ? $urandom_range(0, 26) : 27 + $urandom_range(0, 2);
            end else begin
               flags   = flags & ~MB1_FB_FLAG;
               n_after = $urandom_range(0, 2);
            end
            run_mb1(base, flags, n_after);
         end else begin
            case ($urandom_range(0, 3))
               0: w = MAGIC_MB1;
               1: w = MAGIC_MB2;
               default: w = $urandom;
            endcase
            send_word(logic'($urandom_range(0, 1)), w,
                      ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom);
         end
         seq++;
      end
      calm = 1'b0;
   endtask

   initial begin
      int drain;
      clear_parse();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_words();
      test_start_rejects();
      test_mb1_plain();
      test_mb2_short_total();
      test_mb2_end_tag();
      test_tag_too_small();
      test_abandoned_parse();
      test_random_streams();

      @(negedge clock);
      req_valid <= 1'b0;
      drain = 0;
      while (summaries_due.size() != 0 && drain < 2000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (summaries_due.size() != 0)
         note_fault("summaries never issued", 64'd0, 64'(summaries_due.size()));
      if (fault_count == 0)
         $display("tb_multiboot_info_parser_top: done, clean");
      else
         $display("tb_multiboot_info_parser_top: done, errors");
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("tb_multiboot_info_parser_top: done, errors");
      $finish;
   end

endmodule

>>> multiboot_info_parser_top.f
rtl/mbi_pkg.sv
rtl/multiboot_info_parser_top.sv
tb/tb_multiboot_info_parser_top.sv
